[design/lob_pkg.sv]
// Shared codes and types for the limit order book matcher.
package lob_pkg;

  // Request modes.
  localparam logic [1:0] MODE_LIMIT  = 2'd0;
  localparam logic [1:0] MODE_MARKET = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  // Response status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  // Fraction bits of the average fill price.
  localparam int AVG_FRAC = 8;

  // Operations broadcast from the controller to every slot cell.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_TRADE  = 3'd2,
    OP_CANCEL = 3'd3,
    OP_REST   = 3'd4
  } cell_op_t;

  // Slot selection that goes with each broadcast operation.
  typedef struct packed {
    cell_op_t op;
    logic [11:0] idx_a;
    logic [11:0] idx_b;
  } cell_ctl_t;

endpackage

[design/lob_cell.sv]
// One order slot of the book, plus one stage of the best-price and read-back scan chain.
module lob_cell #(
  parameter int IW  = 8,
  parameter int PW  = 16,
  parameter int QW  = 24,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  lob_pkg::cell_ctl_t  ctl,
  input  logic                wr_side,
  input  logic [PW-1:0]       wr_limit,
  input  logic [QW-1:0]       wr_qty,
  input  logic [QW-1:0]       take,
  input  logic [PW+QW-1:0]    add,
  input  logic                buy_v_in,
  input  logic [PW-1:0]       buy_px_in,
  input  logic [IW-1:0]       buy_idx_in,
  input  logic [QW-1:0]       buy_left_in,
  input  logic                sell_v_in,
  input  logic [PW-1:0]       sell_px_in,
  input  logic [IW-1:0]       sell_idx_in,
  input  logic [QW-1:0]       sell_left_in,
  input  logic [QW-1:0]       rd_filled_in,
  input  logic [QW-1:0]       rd_left_in,
  input  logic [PW+QW-1:0]    rd_notional_in,
  output logic                buy_v_out,
  output logic [PW-1:0]       buy_px_out,
  output logic [IW-1:0]       buy_idx_out,
  output logic [QW-1:0]       buy_left_out,
  output logic                sell_v_out,
  output logic [PW-1:0]       sell_px_out,
  output logic [IW-1:0]       sell_idx_out,
  output logic [QW-1:0]       sell_left_out,
  output logic [QW-1:0]       rd_filled_out,
  output logic [QW-1:0]       rd_left_out,
  output logic [PW+QW-1:0]    rd_notional_out
);

  localparam logic [IW-1:0] ME = IW'(IDX);

  logic              side;
  logic [PW-1:0]     limit;
  logic [QW-1:0]     left;
  logic [QW-1:0]     filled;
  logic [PW+QW-1:0]  notional;
  logic              resting;

  logic hit_a;
  logic hit_b;
  logic hit_rd;
  logic buy_win;
  logic sell_win;

  assign hit_a  = ctl.idx_a[IW-1:0] == ME;
  assign hit_b  = ctl.idx_b[IW-1:0] == ME;
  assign hit_rd = ctl.idx_a[IW-1:0] == ME;

  // Slot contents change only on a broadcast that names this slot.
  always_ff @(posedge clk) begin
    case (ctl.op)
      lob_pkg::OP_WRITE: begin
        if (hit_a) begin
          side     <= wr_side;
          limit    <= wr_limit;
          left     <= wr_qty;
          filled   <= '0;
          notional <= '0;
        end
      end
      lob_pkg::OP_TRADE: begin
        if (hit_a || hit_b) begin
          left     <= left - take;
          filled   <= filled + take;
          notional <= notional + add;
        end
      end
      lob_pkg::OP_CANCEL: begin
        if (hit_a) begin
          left <= '0;
        end
      end
      default: ;
    endcase
  end

  // Resting flag; a resting order that is used up leaves the book.
  always_ff @(posedge clk) begin
    if (rst) begin
      resting <= 1'b0;
    end else begin
      case (ctl.op)
        lob_pkg::OP_WRITE:  if (hit_a) resting <= 1'b0;
        lob_pkg::OP_TRADE:  if (hit_b && left == take) resting <= 1'b0;
        lob_pkg::OP_CANCEL: if (hit_a) resting <= 1'b0;
        lob_pkg::OP_REST:   if (hit_a) resting <= 1'b1;
        default: ;
      endcase
    end
  end

  // Strictly better price wins, so the lowest slot keeps a tie.
  assign buy_win  = resting && side && (!buy_v_in || limit > buy_px_in);
  assign sell_win = resting && !side && (!sell_v_in || limit < sell_px_in);

  // Scan stage: pass the running best on to the next cell.
  always_ff @(posedge clk) begin
    buy_v_out     <= buy_v_in || buy_win;
    buy_px_out    <= buy_win ? limit : buy_px_in;
    buy_idx_out   <= buy_win ? ME : buy_idx_in;
    buy_left_out  <= buy_win ? left : buy_left_in;
    sell_v_out    <= sell_v_in || sell_win;
    sell_px_out   <= sell_win ? limit : sell_px_in;
    sell_idx_out  <= sell_win ? ME : sell_idx_in;
    sell_left_out <= sell_win ? left : sell_left_in;
    rd_filled_out   <= hit_rd ? filled : rd_filled_in;
    rd_left_out     <= hit_rd ? left : rd_left_in;
    rd_notional_out <= hit_rd ? notional : rd_notional_in;
  end

endmodule

[design/limit_order_book_matcher.sv]
// Top level: price-time priority order book built on a chain of slot cells.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    mode side price quantity order_slot
//   rsp      out        rsp_valid/rsp_ready    status result_id ... last_price
//
// A query steps through accept, one chain scan and its evaluation, bit-serial
// division and the load. New orders and cancels add a command step; each
// trade adds the TRADE, MUL and APPLY states and a rescan with its evaluation,
// and a limit order that comes to rest adds a command step and a rescan.
// Reset clears the resting flags, the slot count and the last trade price.
// A request is taken while the last response waits; the next one stalls in FIN.
module limit_order_book_matcher #(
  parameter int MAX_ORDERS = 256,
  parameter int PRICE_BITS = 16,
  parameter int QTY_BITS   = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [1:0]                  mode,
  input  logic                        side,
  input  logic [PRICE_BITS-1:0]       price,
  input  logic [QTY_BITS-1:0]         quantity,
  input  logic [$clog2(MAX_ORDERS)-1:0] order_slot,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [1:0]                  status,
  output logic [$clog2(MAX_ORDERS)-1:0] result_id,
  output logic [QTY_BITS-1:0]         filled_qty,
  output logic [QTY_BITS-1:0]         left_qty,
  output logic [QTY_BITS-1:0]         avg_price_q8,
  output logic                        bid_valid,
  output logic [PRICE_BITS-1:0]       bid_price,
  output logic                        offer_valid,
  output logic [PRICE_BITS-1:0]       offer_price,
  output logic signed [PRICE_BITS:0]  spread,
  output logic [PRICE_BITS-1:0]       last_price
);

  localparam int N    = MAX_ORDERS;
  localparam int IW   = $clog2(MAX_ORDERS);
  localparam int CW   = $clog2(MAX_ORDERS + 1);
  localparam int PW   = PRICE_BITS;
  localparam int QW   = QTY_BITS;
  localparam int NW   = PW + QW;
  localparam int DIVW = NW + lob_pkg::AVG_FRAC;
  localparam int DCW  = $clog2(DIVW + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CMD   = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_TRADE = 9'b000010000,
    S_MUL   = 9'b000100000,
    S_APPLY = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t state;

  // Control registers.
  logic [CW-1:0]        next_slot;
  logic [PW-1:0]        last_trade;
  logic [IW-1:0]        scan_cnt;
  logic [DCW-1:0]       div_cnt;
  logic                 final_scan;
  lob_pkg::cell_op_t    cmd_op;
  logic [IW-1:0]        idx_a;
  logic [IW-1:0]        idx_b;

  // Request and order being matched.
  logic                 is_new;
  logic                 is_read;
  logic                 is_limit;
  logic                 ord_side;
  logic [PW-1:0]        ord_limit;
  logic [QW-1:0]        ord_left;
  logic [QW-1:0]        ord_filled;
  logic [NW-1:0]        ord_notional;
  logic [1:0]           res_status;
  logic [IW-1:0]        res_id;

  // Trade step.
  logic [QW-1:0]        take;
  logic [PW-1:0]        trade_px;
  logic [NW-1:0]        prod;

  // Captured results and divider.
  logic [QW-1:0]        res_filled;
  logic [QW-1:0]        res_left;
  logic                 bk_bid_v;
  logic [PW-1:0]        bk_bid;
  logic                 bk_offer_v;
  logic [PW-1:0]        bk_offer;
  logic [DIVW-1:0]      dvd;
  logic [DIVW-1:0]      quot;
  logic [QW-1:0]        rem;
  logic [QW-1:0]        divisor;

  // Scan chain wiring.
  logic                 ch_buy_v     [N+1];
  logic [PW-1:0]        ch_buy_px    [N+1];
  logic [IW-1:0]        ch_buy_idx   [N+1];
  logic [QW-1:0]        ch_buy_left  [N+1];
  logic                 ch_sell_v    [N+1];
  logic [PW-1:0]        ch_sell_px   [N+1];
  logic [IW-1:0]        ch_sell_idx  [N+1];
  logic [QW-1:0]        ch_sell_left [N+1];
  logic [QW-1:0]        ch_rd_filled [N+1];
  logic [QW-1:0]        ch_rd_left   [N+1];
  logic [NW-1:0]        ch_rd_not    [N+1];

  lob_pkg::cell_ctl_t   ctl;

  // Broadcast operation to the cells.
  always_comb begin
    ctl.idx_a = 12'(idx_a);
    ctl.idx_b = 12'(idx_b);
    if (state == S_CMD) begin
      ctl.op = cmd_op;
    end else if (state == S_APPLY) begin
      ctl.op = lob_pkg::OP_TRADE;
    end else begin
      ctl.op = lob_pkg::OP_NONE;
    end
  end

  // Empty token at the head of the chain.
  assign ch_buy_v[0]     = 1'b0;
  assign ch_buy_px[0]    = '0;
  assign ch_buy_idx[0]   = '0;
  assign ch_buy_left[0]  = '0;
  assign ch_sell_v[0]    = 1'b0;
  assign ch_sell_px[0]   = '0;
  assign ch_sell_idx[0]  = '0;
  assign ch_sell_left[0] = '0;
  assign ch_rd_filled[0] = '0;
  assign ch_rd_left[0]   = '0;
  assign ch_rd_not[0]    = '0;

  // Row of slot cells.
  for (genvar i = 0; i < N; i++) begin : g_cell
    lob_cell #(.IW(IW), .PW(PW), .QW(QW), .IDX(i)) u_cell (
      .clk             (clk),
      .rst             (rst),
      .ctl             (ctl),
      .wr_side         (ord_side),
      .wr_limit        (ord_limit),
      .wr_qty          (ord_left),
      .take            (take),
      .add             (prod),
      .buy_v_in        (ch_buy_v[i]),
      .buy_px_in       (ch_buy_px[i]),
      .buy_idx_in      (ch_buy_idx[i]),
      .buy_left_in     (ch_buy_left[i]),
      .sell_v_in       (ch_sell_v[i]),
      .sell_px_in      (ch_sell_px[i]),
      .sell_idx_in     (ch_sell_idx[i]),
      .sell_left_in    (ch_sell_left[i]),
      .rd_filled_in    (ch_rd_filled[i]),
      .rd_left_in      (ch_rd_left[i]),
      .rd_notional_in  (ch_rd_not[i]),
      .buy_v_out       (ch_buy_v[i+1]),
      .buy_px_out      (ch_buy_px[i+1]),
      .buy_idx_out     (ch_buy_idx[i+1]),
      .buy_left_out    (ch_buy_left[i+1]),
      .sell_v_out      (ch_sell_v[i+1]),
      .sell_px_out     (ch_sell_px[i+1]),
      .sell_idx_out    (ch_sell_idx[i+1]),
      .sell_left_out   (ch_sell_left[i+1]),
      .rd_filled_out   (ch_rd_filled[i+1]),
      .rd_left_out     (ch_rd_left[i+1]),
      .rd_notional_out (ch_rd_not[i+1])
    );
  end

  // Best opposite order at the end of a scan, and the match decision.
  logic           opp_v;
  logic [PW-1:0]  opp_px;
  logic [IW-1:0]  opp_idx;
  logic [QW-1:0]  opp_left;
  logic           px_ok;
  logic           do_trade;
  logic           do_rest;
  logic           table_full;
  logic           id_unknown;
  logic [QW-1:0]  cap_filled;
  logic [QW-1:0]  cap_left;
  logic [NW-1:0]  cap_notional;

  assign opp_v    = ord_side ? ch_sell_v[N] : ch_buy_v[N];
  assign opp_px   = ord_side ? ch_sell_px[N] : ch_buy_px[N];
  assign opp_idx  = ord_side ? ch_sell_idx[N] : ch_buy_idx[N];
  assign opp_left = ord_side ? ch_sell_left[N] : ch_buy_left[N];
  assign px_ok    = !is_limit || (ord_side ? (opp_px <= ord_limit) : (opp_px >= ord_limit));
  assign do_trade = !final_scan && ord_left != '0 && opp_v && px_ok;
  assign do_rest  = !final_scan && is_limit && ord_left != '0;

  assign table_full = next_slot == CW'(MAX_ORDERS);
  assign id_unknown = CW'(order_slot) >= next_slot;

  assign cap_filled   = is_new ? ord_filled : (is_read ? ch_rd_filled[N] : '0);
  assign cap_left     = is_new ? ord_left : (is_read ? ch_rd_left[N] : '0);
  assign cap_notional = is_new ? ord_notional : (is_read ? ch_rd_not[N] : '0);

  // One restoring division step per cycle.
  logic [QW:0] rem_sh;
  logic        div_ge;
  logic [QW:0] rem_sub;

  assign rem_sh  = {rem, dvd[DIVW-1]};
  assign div_ge  = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  assign req_ready = state == S_IDLE;

  // Controller.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_slot  <= '0;
      last_trade <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // The output register empties when taken, unless FIN refills it.
      if (rsp_valid && rsp_ready && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            scan_cnt   <= '0;
            is_new     <= 1'b0;
            is_read    <= 1'b0;
            res_status <= lob_pkg::ST_OK;
            case (mode)
              lob_pkg::MODE_LIMIT, lob_pkg::MODE_MARKET: begin
                if (table_full) begin
                  res_status <= lob_pkg::ST_FULL;
                  res_id     <= '0;
                  final_scan <= 1'b1;
                  state      <= S_SCAN;
                end else begin
                  is_new       <= 1'b1;
                  is_limit     <= mode == lob_pkg::MODE_LIMIT;
                  ord_side     <= side;
                  ord_limit    <= (mode == lob_pkg::MODE_LIMIT) ? price : '0;
                  ord_left     <= quantity;
                  ord_filled   <= '0;
                  ord_notional <= '0;
                  idx_a        <= next_slot[IW-1:0];
                  res_id       <= next_slot[IW-1:0];
                  next_slot    <= next_slot + CW'(1);
                  cmd_op       <= lob_pkg::OP_WRITE;
                  final_scan   <= 1'b0;
                  state        <= S_CMD;
                end
              end
              lob_pkg::MODE_CANCEL, lob_pkg::MODE_QUERY: begin
                res_id     <= order_slot;
                idx_a      <= order_slot;
                final_scan <= 1'b1;
                is_limit   <= 1'b0;
                if (id_unknown) begin
                  res_status <= lob_pkg::ST_UNKNOWN;
                  state      <= S_SCAN;
                end else begin
                  is_read <= 1'b1;
                  if (mode == lob_pkg::MODE_CANCEL) begin
                    cmd_op <= lob_pkg::OP_CANCEL;
                    state  <= S_CMD;
                  end else begin
                    state <= S_SCAN;
                  end
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CMD: begin
          scan_cnt <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + IW'(1);
          if (scan_cnt == IW'(N - 1)) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (do_trade) begin
            state <= S_TRADE;
          end else if (do_rest) begin
            cmd_op     <= lob_pkg::OP_REST;
            final_scan <= 1'b1;
            state      <= S_CMD;
          end else begin
            // Book state after the request, and the order's figures.
            bk_bid_v   <= ch_buy_v[N];
            bk_bid     <= ch_buy_v[N] ? ch_buy_px[N] : '0;
            bk_offer_v <= ch_sell_v[N];
            bk_offer   <= ch_sell_v[N] ? ch_sell_px[N] : '1;
            res_filled <= cap_filled;
            res_left   <= cap_left;
            divisor    <= cap_filled;
            dvd        <= {cap_notional, {lob_pkg::AVG_FRAC{1'b0}}};
            rem        <= '0;
            div_cnt    <= '0;
            state      <= S_DIV;
          end
        end
        S_TRADE: begin
          take     <= (ord_left < opp_left) ? ord_left : opp_left;
          trade_px <= opp_px;
          idx_b    <= opp_idx;
          state    <= S_MUL;
        end
        S_MUL: begin
          prod  <= NW'(trade_px) * NW'(take);
          state <= S_APPLY;
        end
        S_APPLY: begin
          ord_left     <= ord_left - take;
          ord_filled   <= ord_filled + take;
          ord_notional <= ord_notional + prod;
          last_trade   <= trade_px;
          scan_cnt     <= '0;
          state        <= S_SCAN;
        end
        S_DIV: begin
          rem     <= div_ge ? rem_sub[QW-1:0] : rem_sh[QW-1:0];
          dvd     <= {dvd[DIVW-2:0], 1'b0};
          quot    <= {quot[DIVW-2:0], div_ge};
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(DIVW - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid    <= 1'b1;
            status       <= res_status;
            result_id    <= res_id;
            filled_qty   <= res_filled;
            left_qty     <= res_left;
            avg_price_q8 <= (res_filled == '0) ? '0 : quot[QW-1:0];
            bid_valid    <= bk_bid_v;
            bid_price    <= bk_bid;
            offer_valid  <= bk_offer_v;
            offer_price  <= bk_offer;
            spread       <= (bk_bid_v && bk_offer_v) ?
                            ($signed({1'b0, bk_offer}) - $signed({1'b0, bk_bid})) : '0;
            last_price   <= last_trade;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Slot count never passes the table size.
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    next_slot <= CW'(MAX_ORDERS))
    else $error("slot count beyond table size");

  // An accepted new order with room takes exactly one slot.
  a_slot_take: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && !table_full &&
     (mode == lob_pkg::MODE_LIMIT || mode == lob_pkg::MODE_MARKET))
    |=> next_slot == $past(next_slot) + CW'(1))
    else $error("new order did not take a slot");

  // A trade always moves a nonzero quantity.
  a_take_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY |-> take != '0)
    else $error("zero quantity trade");

  // A rejected order reports no fills.
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == lob_pkg::ST_FULL) |-> (filled_qty == '0 && left_qty == '0))
    else $error("rejected order reports quantity");

endmodule
